// ===== src/ils_pkg.sv =====
// Shared definitions for the indexed list store.
// Operation and status codes plus the sequencer state type; no dependencies.
`default_nettype none

package ils_pkg;

  // operation selector of a request
  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_POP    = 2'd1,
    FN_READ   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  // status code of a result
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  // data returned on any error
  localparam logic [31:0] ERR_DATA = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== src/ils_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/indexed_list_store_core.sv =====
// Indexed list store: bounded ordered list of signed 32-bit values.
// Depends on ils_pkg and ils_ram.
//
// Usage: one request on the input channel (in_valid_i / in_stall_o) carries
// func_i (append, pop at position, read at position), value_i and
// position_i; position -1 means the last entry for pop. Each request gives
// exactly one result on the output channel (out_valid_o / out_stall_i):
// data_o, status_o and the list length after the operation. Errors leave
// the list unchanged and return data -1 with a status code.
// Append, an unused selector and every error go straight from decode to the
// hand-over state; read first fetches the entry from the entry RAM; pop
// fetches the entry and then moves the entries behind the popped one down
// one per cycle through the single write port of the entry RAM.
// The next request is taken in the cycle after the result enters the output
// register, so a new request is not taken before the previous result is
// handed over; a pop from the front of a full list takes longest.
// Reset clears the length and the output valid; the entry RAM is not
// cleared, only entries below the length are ever read.
// While the receiver stalls, the result is held in the output register and
// one further request may finish into a holding stage before in_stall_o stays high.
`default_nettype none

module indexed_list_store_core
  import ils_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [1:0]  func_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [8:0]  position_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [31:0] data_o,
  output logic             [1:0]  status_o,
  output logic             [8:0]  length_o
);

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int CmpW  = (CntW > 9) ? CntW : 9;
  localparam int XW    = CntW + 1;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic              is_pop_q, is_pop_d;
  logic [31:0]       res_data_q, res_data_d;
  status_e           res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_data_q, out_data_d;
  status_e           out_status_q, out_status_d;
  logic [8:0]        out_length_q, out_length_d;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic [CmpW-1:0]   count_ext, pos_ext;
  logic [CntW-1:0]   count_m1;
  logic [XW-1:0]     ptr_x, next1, next2, count_x;
  logic              pos_neg, pos_last, pos_in, full, in_accept;

  // entry store
  ils_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // position and length checks
  assign count_ext = CmpW'(count_q);
  assign pos_ext   = CmpW'(position_i[7:0]);
  assign pos_neg   = position_i[8];
  assign pos_last  = &position_i;
  assign pos_in    = !pos_neg && (pos_ext < count_ext);
  assign count_m1  = count_q - CntW'(1);
  assign full      = (count_q == CntW'(CAPACITY));
  assign ptr_x     = XW'(ptr_q);
  assign next1     = ptr_x + XW'(1);
  assign next2     = ptr_x + XW'(2);
  assign count_x   = XW'(count_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = (state_q == S_IDLE) && in_valid_i;

  // sequencer: decode, fetch, shift down, hand over
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    is_pop_d     = is_pop_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_length_d = out_length_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_data_d   = '0;
          res_status_d = STAT_OK;
          state_d      = S_DONE;
          case (func_e'(func_i))
            FN_APPEND: begin
              if (full) begin
                res_data_d   = ERR_DATA;
                res_status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AddrW-1:0];
                ram_wdata = $unsigned(value_i);
                count_d   = count_q + CntW'(1);
              end
            end
            FN_POP: begin
              if (count_q == '0) begin
                res_data_d   = ERR_DATA;
                res_status_d = STAT_EMPTY;
              end else if (pos_last || pos_in) begin
                ptr_d     = pos_last ? count_m1[AddrW-1:0] : pos_ext[AddrW-1:0];
                ram_re    = 1'b1;
                ram_raddr = ptr_d;
                is_pop_d  = 1'b1;
                state_d   = S_FETCH;
              end else begin
                res_data_d   = ERR_DATA;
                res_status_d = STAT_RANGE;
              end
            end
            FN_READ: begin
              if (pos_in) begin
                ptr_d     = pos_ext[AddrW-1:0];
                ram_re    = 1'b1;
                ram_raddr = ptr_d;
                is_pop_d  = 1'b0;
                state_d   = S_FETCH;
              end else begin
                res_data_d   = ERR_DATA;
                res_status_d = STAT_RANGE;
              end
            end
            default: begin
              res_data_d   = '0;
              res_status_d = STAT_OK;
            end
          endcase
        end
      end
      S_FETCH: begin
        res_data_d   = ram_rdata;
        res_status_d = STAT_OK;
        if (is_pop_q) begin
          if (next1 < count_x) begin
            ram_re    = 1'b1;
            ram_raddr = next1[AddrW-1:0];
            state_d   = S_SHIFT;
          end else begin
            count_d = count_m1;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        // move the entry behind the gap down by one
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        if (next2 < count_x) begin
          ram_re    = 1'b1;
          ram_raddr = next2[AddrW-1:0];
          ptr_d     = next1[AddrW-1:0];
        end else begin
          count_d = count_m1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          out_length_d = count_ext[8:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    is_pop_q     <= is_pop_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_length_q <= out_length_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign length_o    = out_length_q;

endmodule

`default_nettype wire

// ===== src/ils_checker.sv =====
// Port-level checks for the indexed list store, bound to the top level.
// Depends on ils_pkg.
`default_nettype none

module ils_checker
  import ils_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic signed [31:0] data_o,
  input wire logic        [1:0] status_o,
  input wire logic        [8:0] length_o
);

  localparam logic [8:0] CapLen = 9'(CAPACITY);

  // a stalled result stays and does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_o) &&
      $stable(status_o) && $stable(length_o))
    else $error("stalled result changed");

  // every error returns all ones as data
  a_err_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> data_o == -32'sd1)
    else $error("error result without all-ones data");

  // an empty-list error reports zero length
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> length_o == 9'd0)
    else $error("empty status with nonzero length");

  // a full error reports the capacity as length
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> length_o == CapLen)
    else $error("full status with wrong length");

endmodule

bind indexed_list_store_core ils_checker #(
  .CAPACITY(CAPACITY)
) u_ils_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .data_o     (data_o),
  .status_o   (status_o),
  .length_o   (length_o)
);

`default_nettype wire
